// File: hw/rtl/egcd_pkg.sv
// ----------------------------------------------------------------------------
// Extended GCD package
// Shared types and constants for the extended gcd and lcm unit.
// ----------------------------------------------------------------------------
package egcd_pkg;

  localparam int unsigned TARGET_W = 32;

  typedef struct packed {
    logic step;
    logic qbit;
    logic done;
  } div_stat_t;

endpackage

// File: hw/rtl/egcd_div.sv
// ----------------------------------------------------------------------------
// Serial divider
// Restoring divider that produces one quotient bit per cycle from a
// left-aligned dividend of programmable length.
// ----------------------------------------------------------------------------
module egcd_div #(
  parameter int unsigned VB = 31,
  parameter int unsigned N  = 64,
  parameter int unsigned LW = 7
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [N-1:0]         dividend_i,
  input  logic [LW-1:0]        len_i,
  input  logic [VB-1:0]        divisor_i,
  output egcd_pkg::div_stat_t  stat_o,
  output logic [N-1:0]         quo_o,
  output logic [VB-1:0]        rem_o
);
  import egcd_pkg::*;

  logic [N-1:0]  num_q;
  logic [N-1:0]  quo_q;
  logic [VB-1:0] rem_q;
  logic [VB-1:0] div_q;
  logic [LW-1:0] cnt_q;
  logic          busy_q;
  logic          done_q;
  logic [VB:0]   trial;
  logic [VB:0]   diff;
  logic          ge;

  assign trial = {rem_q, num_q[N-1]};
  assign ge    = trial >= {1'b0, div_q};
  assign diff  = trial - {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_q  <= '0;
      quo_q  <= '0;
      rem_q  <= '0;
      div_q  <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      if (start_i) begin
        num_q  <= dividend_i;
        quo_q  <= '0;
        rem_q  <= '0;
        div_q  <= divisor_i;
        cnt_q  <= len_i;
        busy_q <= 1'b1;
        done_q <= 1'b0;
      end else if (busy_q) begin
        num_q  <= {num_q[N-2:0], 1'b0};
        quo_q  <= {quo_q[N-2:0], ge};
        rem_q  <= ge ? diff[VB-1:0] : trial[VB-1:0];
        cnt_q  <= cnt_q - LW'(1);
        done_q <= cnt_q == LW'(1);
        if (cnt_q == LW'(1)) begin
          busy_q <= 1'b0;
        end
      end else begin
        done_q <= 1'b0;
      end
    end
  end

  assign stat_o.step = busy_q;
  assign stat_o.qbit = ge;
  assign stat_o.done = done_q;
  assign quo_o       = quo_q;
  assign rem_o       = rem_q;

endmodule

// File: hw/rtl/extended_gcd_lcm_unit.sv
// ----------------------------------------------------------------------------
// Extended GCD and LCM unit
// Extended Euclid with Bezout coefficients, lcm and scaled Diophantine
// solution, all divisions on one serial divider under a small sequencer.
// ----------------------------------------------------------------------------
// One request at a time: each Euclid step runs on the shared
// one-bit-per-cycle divider, then come the remainder check of c, the
// quotient b/g, the lcm shift-add, and for each of the two scaled
// solutions a multiply followed by a divide. The number of Euclid steps
// depends on the operands (at most about 46 for 31 bits). Input stall is
// high from acceptance until the result enters the output register.
module extended_gcd_lcm_unit #(
  parameter int unsigned VALUE_BITS = 31
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [VALUE_BITS-1:0] first_value_i,
  input  logic [VALUE_BITS-1:0] second_value_i,
  input  logic signed [31:0]    target_sum_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [VALUE_BITS-1:0] divisor_o,
  output logic signed [31:0]    coef_x_o,
  output logic signed [31:0]    coef_y_o,
  output logic [VALUE_BITS-1:0] multiple_o,
  output logic signed [31:0]    solution_x_o,
  output logic signed [31:0]    solution_y_o,
  output logic                  both_zero_o,
  output logic                  multiple_overflow_o,
  output logic                  not_divisible_o,
  output logic                  solution_overflow_o
);
  import egcd_pkg::*;

  localparam int unsigned VB = VALUE_BITS;
  localparam int unsigned CW = VB + 2;
  localparam int unsigned MW = VB + 1;
  localparam int unsigned PW = MW + TARGET_W;
  localparam int unsigned LW = $clog2(PW + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_CHK, S_EUC, S_MOD, S_BQ, S_LCM, S_SMUL, S_SDIV, S_FIN
  } state_e;

  state_e                state_q;
  logic [VB-1:0]         a_q, b_q, r0_q, r1_q, bq_q;
  logic signed [31:0]    c_q;
  logic signed [CW-1:0]  s0_q, s1_q, t0_q, t1_q, ps_q, pt_q;
  logic [VB-1:0]         acc_q;
  logic                  lov_q, ndiv_q, sov_q, sel_q;
  logic [MW-1:0]         mag_q;
  logic [31:0]           mt_q;
  logic                  neg_q;
  logic [PW-1:0]         prod_q;
  logic [LW-1:0]         cnt_q;
  logic [31:0]           solx_q;

  logic                  out_valid_q, bz_q, lovo_q, ndivo_q, sovo_q;
  logic [VB-1:0]         g_o_q, lcm_o_q;
  logic [31:0]           cx_q, cy_q, sx_q, sy_q;

  logic                  div_start;
  logic [PW-1:0]         div_dividend;
  logic [LW-1:0]         div_len;
  logic [VB-1:0]         div_divisor;
  div_stat_t             div_stat;
  logic [PW-1:0]         div_quo;
  logic [VB-1:0]         div_rem;

  logic [31:0]           c_mag;
  logic [VB+1:0]         acc_nxt;
  logic signed [63:0]    s0_ext, t0_ext;
  logic signed [CW-1:0]  coef_sel;
  logic [MW-1:0]         coef_mag;
  logic                  coef_neg;
  logic [PW-1:0]         lim;
  logic                  q_over;
  logic [32:0]           q_mag;
  logic [32:0]           q_signed;

  assign c_mag    = c_q[31] ? 32'(-c_q) : 32'(c_q);
  assign acc_nxt  = {1'b0, acc_q, 1'b0} + (bq_q[VB-1] ? (VB+2)'(a_q) : '0);
  assign s0_ext   = 64'(s0_q);
  assign t0_ext   = 64'(t0_q);
  assign coef_sel = sel_q ? t0_q : s0_q;
  assign coef_neg = coef_sel[CW-1];
  assign coef_mag = coef_neg ? MW'(-coef_sel) : MW'(coef_sel);
  assign lim      = neg_q ? PW'(33'h1_0000_0000 >> 1) : PW'(32'h7FFF_FFFF);
  assign q_over   = div_quo > lim;
  assign q_mag    = q_over ? lim[32:0] : div_quo[32:0];
  assign q_signed = neg_q ? -q_mag : q_mag;

  always_comb begin
    div_start    = 1'b0;
    div_dividend = {r0_q, {(PW-VB){1'b0}}};
    div_len      = LW'(VB);
    div_divisor  = r1_q;
    case (state_q)
      S_CHK: begin
        if (r1_q != '0) begin
          div_start = 1'b1;
        end else if (r0_q != '0) begin
          div_start    = 1'b1;
          div_dividend = {c_mag, {(PW-TARGET_W){1'b0}}};
          div_len      = LW'(TARGET_W);
          div_divisor  = r0_q;
        end
      end
      S_MOD: begin
        div_start    = div_stat.done;
        div_dividend = {b_q, {(PW-VB){1'b0}}};
        div_divisor  = r0_q;
      end
      S_SMUL: begin
        div_start    = (cnt_q == '0);
        div_dividend = prod_q;
        div_len      = LW'(PW);
        div_divisor  = r0_q;
      end
      default: begin
      end
    endcase
  end

  egcd_div #(
    .VB(VB),
    .N (PW),
    .LW(LW)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(div_dividend),
    .len_i     (div_len),
    .divisor_i (div_divisor),
    .stat_o    (div_stat),
    .quo_o     (div_quo),
    .rem_o     (div_rem)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      a_q <= '0; b_q <= '0; r0_q <= '0; r1_q <= '0; bq_q <= '0; c_q <= '0;
      s0_q <= '0; s1_q <= '0; t0_q <= '0; t1_q <= '0; ps_q <= '0; pt_q <= '0;
      acc_q <= '0; lov_q <= 1'b0; ndiv_q <= 1'b0; sov_q <= 1'b0; sel_q <= 1'b0;
      mag_q <= '0; mt_q <= '0; neg_q <= 1'b0; prod_q <= '0; cnt_q <= '0;
      solx_q <= '0;
      bz_q <= 1'b0; lovo_q <= 1'b0; ndivo_q <= 1'b0; sovo_q <= 1'b0;
      g_o_q <= '0; lcm_o_q <= '0; cx_q <= '0; cy_q <= '0; sx_q <= '0; sy_q <= '0;
    end else begin
      if (out_valid_q && !out_stall_i && state_q != S_FIN) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            a_q     <= first_value_i;
            b_q     <= second_value_i;
            r0_q    <= first_value_i;
            r1_q    <= second_value_i;
            c_q     <= target_sum_i;
            s0_q    <= CW'(1);
            s1_q    <= '0;
            t0_q    <= '0;
            t1_q    <= CW'(1);
            lov_q   <= 1'b0;
            sov_q   <= 1'b0;
            sel_q   <= 1'b0;
            state_q <= S_CHK;
          end
        end
        S_CHK: begin
          ps_q <= '0;
          pt_q <= '0;
          if (r1_q != '0) begin
            state_q <= S_EUC;
          end else if (r0_q != '0) begin
            state_q <= S_MOD;
          end else begin
            ndiv_q  <= c_q != '0;
            acc_q   <= '0;
            solx_q  <= '0;
            prod_q  <= '0;
            state_q <= S_FIN;
          end
        end
        S_EUC: begin
          if (div_stat.step) begin
            ps_q <= (ps_q <<< 1) + (div_stat.qbit ? s1_q : '0);
            pt_q <= (pt_q <<< 1) + (div_stat.qbit ? t1_q : '0);
          end
          if (div_stat.done) begin
            r0_q    <= r1_q;
            r1_q    <= div_rem;
            s0_q    <= s1_q;
            s1_q    <= s0_q - ps_q;
            t0_q    <= t1_q;
            t1_q    <= t0_q - pt_q;
            state_q <= S_CHK;
          end
        end
        S_MOD: begin
          if (div_stat.done) begin
            ndiv_q  <= div_rem != '0;
            state_q <= S_BQ;
          end
        end
        S_BQ: begin
          if (div_stat.done) begin
            bq_q    <= div_quo[VB-1:0];
            acc_q   <= '0;
            cnt_q   <= LW'(VB);
            state_q <= S_LCM;
          end
        end
        S_LCM: begin
          if (acc_nxt[VB+1:VB] != '0) begin
            lov_q <= 1'b1;
          end
          acc_q <= acc_nxt[VB-1:0];
          bq_q  <= {bq_q[VB-2:0], 1'b0};
          if (cnt_q == LW'(1)) begin
            mag_q   <= coef_mag;
            neg_q   <= coef_neg != c_q[31];
            mt_q    <= c_mag;
            prod_q  <= '0;
            cnt_q   <= LW'(TARGET_W);
            state_q <= S_SMUL;
          end else begin
            cnt_q <= cnt_q - LW'(1);
          end
        end
        S_SMUL: begin
          if (cnt_q == '0) begin
            state_q <= S_SDIV;
          end else begin
            prod_q <= {prod_q[PW-2:0], 1'b0} + (mt_q[31] ? PW'(mag_q) : '0);
            mt_q   <= {mt_q[30:0], 1'b0};
            cnt_q  <= cnt_q - LW'(1);
          end
        end
        S_SDIV: begin
          if (div_stat.done) begin
            if (q_over) begin
              sov_q <= 1'b1;
            end
            if (!sel_q) begin
              solx_q  <= q_signed[31:0];
              sel_q   <= 1'b1;
              mag_q   <= MW'(t0_q[CW-1] ? -t0_q : t0_q);
              neg_q   <= t0_q[CW-1] != c_q[31];
              mt_q    <= c_mag;
              prod_q  <= '0;
              cnt_q   <= LW'(TARGET_W);
              state_q <= S_SMUL;
            end else begin
              prod_q  <= PW'(q_signed[31:0]);
              state_q <= S_FIN;
            end
          end
        end
        S_FIN: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q <= 1'b1;
            bz_q        <= r0_q == '0;
            g_o_q       <= r0_q;
            cx_q        <= s0_ext[31:0];
            cy_q        <= t0_ext[31:0];
            lcm_o_q     <= lov_q ? '1 : acc_q;
            lovo_q      <= lov_q;
            ndivo_q     <= ndiv_q;
            sovo_q      <= sov_q;
            sx_q        <= solx_q;
            sy_q        <= prod_q[31:0];
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign in_stall_o          = state_q != S_IDLE;
  assign out_valid_o         = out_valid_q;
  assign divisor_o           = g_o_q;
  assign coef_x_o            = cx_q;
  assign coef_y_o            = cy_q;
  assign multiple_o          = lcm_o_q;
  assign solution_x_o        = sx_q;
  assign solution_y_o        = sy_q;
  assign both_zero_o         = bz_q;
  assign multiple_overflow_o = lovo_q;
  assign not_divisible_o     = ndivo_q;
  assign solution_overflow_o = sovo_q;

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("unit accepted a request without going busy");

  a_zero_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && both_zero_o |-> multiple_o == '0 && !multiple_overflow_o
      && !solution_overflow_o)
    else $error("both-zero result carries a nonzero lcm or overflow");

  a_lcm_saturated: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && multiple_overflow_o |-> &multiple_o)
    else $error("lcm overflow without saturation");

  a_gcd_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !both_zero_o |-> divisor_o != '0)
    else $error("zero gcd without both-zero flag");

endmodule
